>>> hw/rtl/asfc_pkg.sv
package asfc_pkg;

  // Result codes
  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_SHORT     = 2'd1,
    VERDICT_BAD_SUM   = 2'd2,
    VERDICT_BAD_TYPE  = 2'd3
  } verdict_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_BYTE      = 2'd0,
    CFG_END_BYTE        = 2'd1,
    CFG_EXPECTED_COMMAS = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_index_t;

  localparam logic [7:0] START_BYTE_RESET      = 8'h24;
  localparam logic [7:0] END_BYTE_RESET        = 8'h0D;
  localparam logic [7:0] EXPECTED_COMMAS_RESET = 8'd10;

  localparam logic [7:0] COMMA_CHAR  = 8'h2C;
  localparam int unsigned MIN_BODY   = 9;
  localparam int unsigned WINDOW     = 3;
  localparam int unsigned PREFIX_LEN = 6;

  // Sentence type prefix "VNCMV,"
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h56;
      3'd1:    c = 8'h4E;
      3'd2:    c = 8'h43;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h56;
      3'd5:    c = COMMA_CHAR;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/asfc_rx_if.sv
interface asfc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/asfc_res_if.sv
interface asfc_res_if import asfc_pkg::*; ();
  logic       valid;
  logic       ready;
  verdict_t   verdict;
  logic [7:0] body_length;
  logic [7:0] computed_sum;
  logic       hit_limit;

  modport source (output valid, output verdict, output body_length,
                  output computed_sum, output hit_limit, input ready);
  modport sink   (input valid, input verdict, input body_length,
                  input computed_sum, input hit_limit, output ready);
endinterface

>>> hw/rtl/ascii_sentence_framer_checker.sv
// ASCII sentence framer and checker.
// Channel rx carries received serial bytes (valid/ready). Bytes are dropped
// until start_byte, then the body is collected until end_byte or until
// MAX_FRAME_BYTES bytes are held. At each frame close one request goes out on
// channel res: verdict (ok, too short, checksum bad, wrong type or field
// count), body length, the XOR of the body without its last three bytes, and
// whether the length limit closed the frame.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (start byte, end byte, expected comma count); index 3 is ignored.
// Throughput: one byte per cycle while not stalled (see below). A byte goes
// into an input register at acceptance and is processed from there; the
// result register loads when the closing byte leaves the input register,
// and res is driven from the result register.
// Stall: when res is not taken, the result register holds and bytes keep
// flowing; the pipe stops only when the byte in the input register would
// close another frame, and rx.ready then stays low until res is taken.
// Reset (rst, synchronous): registers return to '$', CR and 10 commas; the
// framer hunts for a start byte and both pipe registers are empty.
module ascii_sentence_framer_checker import asfc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [7:0]       cfg_data,
  asfc_rx_if.sink          rx,
  asfc_res_if.source       res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration registers
  logic [7:0] start_byte;
  logic [7:0] end_byte;
  logic [7:0] expected_commas;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RESET;
      end_byte        <= END_BYTE_RESET;
      expected_commas <= EXPECTED_COMMAS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:      start_byte      <= cfg_data;
        CFG_END_BYTE:        end_byte        <= cfg_data;
        CFG_EXPECTED_COMMAS: expected_commas <= cfg_data;
        default: ;
      endcase
    end
  end

  // Framer state
  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       recent_bytes [WINDOW];
  logic [7:0]       recent_bytes_next [WINDOW];
  logic [7:0]       comma_total, comma_total_next;
  logic             prefix_match, prefix_match_next;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;

  // Result register
  logic       res_valid;
  verdict_t   res_verdict;
  logic [7:0] res_length;
  logic [7:0] res_sum;
  logic       res_limit;

  // Values after pushing the held byte into the body
  logic [CNT_W-1:0] p_count;
  logic [7:0]       p_xor;
  logic [7:0]       p_comma;
  logic             p_prefix;
  logic [CNT_W-1:0] pos;
  logic [7:0]       old_byte;

  // Values seen at frame close
  logic [CNT_W-1:0] f_count;
  logic [7:0]       f_xor;
  logic [7:0]       f_comma;
  logic             f_prefix;
  logic [7:0]       f_hi;
  logic [7:0]       f_lo;

  logic     is_start;
  logic     is_end;
  logic     at_limit;
  logic     emit;
  logic     advance;
  verdict_t verdict_next;

  assign is_start = (in_byte == start_byte);
  assign is_end   = (in_byte == end_byte);

  // Window push: oldest byte leaves into the XOR, comma and prefix checks
  always_comb begin
    old_byte = recent_bytes[WINDOW-1];
    pos      = byte_count - CNT_W'(WINDOW);
    p_count  = byte_count + CNT_W'(1);
    p_xor    = running_xor;
    p_comma  = comma_total;
    p_prefix = prefix_match;
    if (byte_count >= CNT_W'(WINDOW)) begin
      p_xor = running_xor ^ old_byte;
      if (old_byte == COMMA_CHAR && comma_total != 8'hFF) begin
        p_comma = comma_total + 8'd1;
      end
      if (pos < CNT_W'(PREFIX_LEN) && old_byte != prefix_char(pos[2:0])) begin
        p_prefix = 1'b0;
      end
    end
  end

  assign at_limit = (p_count == CNT_W'(MAX_FRAME_BYTES));
  assign emit     = in_frame && (is_end || at_limit);
  assign advance  = in_valid && (!emit || !res_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  // Close values: end byte uses the body as is, limit uses the pushed body
  always_comb begin
    if (is_end) begin
      f_count  = byte_count;
      f_xor    = running_xor;
      f_comma  = comma_total;
      f_prefix = prefix_match;
      f_hi     = recent_bytes[1];
      f_lo     = recent_bytes[0];
    end else begin
      f_count  = p_count;
      f_xor    = p_xor;
      f_comma  = p_comma;
      f_prefix = p_prefix;
      f_hi     = recent_bytes[0];
      f_lo     = in_byte;
    end
  end

  // Verdict, in priority order
  always_comb begin
    if (f_count < CNT_W'(MIN_BODY)) begin
      verdict_next = VERDICT_SHORT;
    end else if (f_hi != hex_digit(f_xor[7:4]) || f_lo != hex_digit(f_xor[3:0])) begin
      verdict_next = VERDICT_BAD_SUM;
    end else if (!f_prefix || f_comma != expected_commas) begin
      verdict_next = VERDICT_BAD_TYPE;
    end else begin
      verdict_next = VERDICT_OK;
    end
  end

  // Framer next state
  always_comb begin
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    comma_total_next     = comma_total;
    prefix_match_next    = prefix_match;
    recent_bytes_next[0] = recent_bytes[0];
    recent_bytes_next[1] = recent_bytes[1];
    recent_bytes_next[2] = recent_bytes[2];
    if (advance) begin
      if (!in_frame) begin
        if (is_start) begin
          in_frame_next        = 1'b1;
          byte_count_next      = '0;
          running_xor_next     = '0;
          comma_total_next     = '0;
          prefix_match_next    = 1'b1;
          recent_bytes_next[0] = '0;
          recent_bytes_next[1] = '0;
          recent_bytes_next[2] = '0;
        end
      end else if (is_end) begin
        in_frame_next = 1'b0;
      end else begin
        byte_count_next      = p_count;
        running_xor_next     = p_xor;
        comma_total_next     = p_comma;
        prefix_match_next    = p_prefix;
        recent_bytes_next[0] = in_byte;
        recent_bytes_next[1] = recent_bytes[0];
        recent_bytes_next[2] = recent_bytes[1];
        if (at_limit) begin
          in_frame_next = 1'b0;
        end
      end
    end
  end

  // State and pipe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_count      <= '0;
      running_xor     <= '0;
      comma_total     <= '0;
      prefix_match    <= 1'b1;
      recent_bytes[0] <= '0;
      recent_bytes[1] <= '0;
      recent_bytes[2] <= '0;
      in_valid        <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      in_frame        <= in_frame_next;
      byte_count      <= byte_count_next;
      running_xor     <= running_xor_next;
      comma_total     <= comma_total_next;
      prefix_match    <= prefix_match_next;
      recent_bytes[0] <= recent_bytes_next[0];
      recent_bytes[1] <= recent_bytes_next[1];
      recent_bytes[2] <= recent_bytes_next[2];
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      if (advance && emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
    if (advance && emit) begin
      res_verdict <= verdict_next;
      res_length  <= 8'(f_count);
      res_sum     <= f_xor;
      res_limit   <= !is_end;
    end
  end

  assign res.valid        = res_valid;
  assign res.verdict      = res_verdict;
  assign res.body_length  = res_length;
  assign res.computed_sum = res_sum;
  assign res.hit_limit    = res_limit;

endmodule
